/* sv/ili_pkg.sv */
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and codes for the positional insert/delete list.
// ----------------------------------------------------------------------------
package ili_pkg;

    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_INSERT    = 3'd1;
    localparam logic [2:0] OP_OVERWRITE = 3'd2;
    localparam logic [2:0] OP_DELETE    = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  position;
        logic [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [6:0]  length;
    } rsp_item_t;

    // per-item command broadcast to every cell; set only for a successful item
    typedef struct packed {
        logic app;
        logic ins;
        logic ovw;
        logic del;
    } cell_cmd_t;

endpackage

/* sv/ili_cell.sv */
// ----------------------------------------------------------------------------
// ili_cell
// One list entry: takes the new word, its left or right neighbor, or holds.
// ----------------------------------------------------------------------------
module ili_cell
    import ili_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 7,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [PW-1:0]         pos,
    input  logic [PW-1:0]         cnt,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  hit
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  at_pos;
    logic                  above_pos;
    logic                  at_end;

    assign at_pos    = (IDX == pos);
    assign above_pos = (IDX > pos);
    assign at_end    = (IDX == cnt);

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.app && at_end)
            data_next = value;
        else if (cmd.ins && above_pos)
            data_next = left;
        else if ((cmd.ins || cmd.ovw) && at_pos)
            data_next = value;
        else if (cmd.del && (above_pos || at_pos))
            data_next = right;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = at_pos;

endmodule

/* sv/indexed_list_insert_delete_top.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top
// Ordered word list in a row of cells: append, insert, overwrite, delete, read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | operation, position, value
//  rsp     | out       | rsp_valid / rsp_stall  | data_out, status, length
//
//  One item per cycle unless stalled; each result follows in the next cycle.
//  All cells shift or load in the accepting cycle, so an item sees the last.
//  Reset clears the count and the result valid flag; cell contents are not reset.
//  req_stall is high only while a result is held and rsp_stall is high.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top
    import ili_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_item_t     rsp_reg;
    rsp_item_t     rsp_next;

    logic                  accept;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         cnt_w;
    logic                  full;
    logic                  in_range;
    logic [63:0]           value_w;
    logic [DATA_WIDTH-1:0] val;
    logic [DATA_WIDTH-1:0] rd;
    logic [63:0]           data_w;
    logic [63:0]           val_w;
    cell_cmd_t             cmd;
    logic [1:0]            status;
    logic                  ret_val;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic                  cell_hit  [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_w    = PW'(req.position);
    assign cnt_w    = PW'(count_reg);
    assign full     = (count_reg == CAP);
    assign in_range = (pos_w < cnt_w);
    assign value_w  = {32'd0, req.value};
    assign val      = value_w[DATA_WIDTH-1:0];

    always_comb
    begin
        cmd        = '0;
        status     = ST_OK;
        ret_val    = 1'b0;
        count_next = count_reg;
        unique case (req.operation)
            OP_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.app    = accept;
                    ret_val    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_INSERT:
            begin
                if (pos_w > cnt_w)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.ins    = accept;
                    ret_val    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_OVERWRITE:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                    cmd.ovw = accept;
            end
            OP_DELETE:
            begin
                if (!in_range)
                    status = ST_RANGE;
                else
                begin
                    cmd.del    = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ:
            begin
                if (!in_range)
                    status = ST_RANGE;
            end
            default:
                status = ST_RANGE;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = cell_data[i];
        end
        else
        begin : g_mid
            assign left = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_inner
            assign right = cell_data[i+1];
        end

        ili_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .INDEX      (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (pos_w),
            .cnt   (cnt_w),
            .value (val),
            .left  (left),
            .right (right),
            .data  (cell_data[i]),
            .hit   (cell_hit[i])
        );
    end

    always_comb
    begin
        rd = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_hit[i])
                rd = rd | cell_data[i];
        end
    end

    always_comb
    begin
        data_w = '0;
        val_w  = '0;
        data_w[DATA_WIDTH-1:0] = rd;
        val_w[DATA_WIDTH-1:0]  = val;
    end

    always_comb
    begin
        rsp_next.status = status;
        rsp_next.length = 7'(count_next);
        if (status != ST_OK)
            rsp_next.data_out = '0;
        else if (ret_val)
            rsp_next.data_out = val_w[31:0];
        else
            rsp_next.data_out = data_w[31:0];
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert/delete list. A scoreboard
// class keeps its own copy of the list and count, predicts one result per
// accepted item and checks each returned item field by field. A short
// directed run hits empty, range and spare-code cases, then mixed random
// traffic grows the list to full and drains it, with random idling on both
// sides and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import ili_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_ITEMS  = 125;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef enum int {PACE_NONE, PACE_SPREAD, PACE_SPARSE} pace_t;
    typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

    class list_scoreboard;
        logic [31:0] words [CAPACITY];
        int          count;
        int          errors;
        rsp_item_t   pending_results [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function rsp_item_t list_outcome(req_item_t r);
            rsp_item_t e;
            int        p;
            int        i;
            e        = '0;
            e.status = ST_OK;
            p        = r.position;
            case (r.operation)
                OP_APPEND:
                    if (count >= CAPACITY)
                        e.status = ST_FULL;
                    else
                    begin
                        words[count] = r.value;
                        count++;
                        e.data_out = r.value;
                    end
                OP_INSERT:
                    if (p > count)
                        e.status = ST_RANGE;
                    else if (count >= CAPACITY)
                        e.status = ST_FULL;
                    else
                    begin
                        for (i = count; i > p; i--)
                            words[i] = words[i - 1];
                        words[p] = r.value;
                        count++;
                        e.data_out = r.value;
                    end
                OP_OVERWRITE:
                    if (p >= count)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.data_out = words[p];
                        words[p]   = r.value;
                    end
                OP_DELETE:
                    if (p >= count)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.data_out = words[p];
                        for (i = p; i + 1 < count; i++)
                            words[i] = words[i + 1];
                        count--;
                    end
                OP_READ:
                    if (p >= count)
                        e.status = ST_RANGE;
                    else
                        e.data_out = words[p];
                default:
                    e.status = ST_RANGE;
            endcase
            e.length = 7'(count);
            return e;
        endfunction

        function void note_request(req_item_t r);
            pending_results.push_back(list_outcome(r));
        endfunction

        task check_result(rsp_item_t got);
            rsp_item_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected item %h", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.data_out !== want.data_out)
                report($sformatf("data_out %h, want %h", got.data_out, want.data_out));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.length !== want.length)
                report($sformatf("length %0d, want %0d", got.length, want.length));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    list_scoreboard board = new();
    int             accepted = 0;
    pace_t          send_pace = PACE_NONE;
    pace_t          take_pace = PACE_NONE;
    logic           hold_rsp = 1'b0;

    indexed_list_insert_delete_top #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_wait(pace_t pace);
        case (pace)
            PACE_NONE:   return 0;
            PACE_SPREAD: return $urandom_range(0, 19);
            default:     return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    task automatic send_item(req_item_t it);
        int gap;
        gap = pick_wait(send_pace);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        board.note_request(it);
        accepted++;
    endtask

    task automatic push(logic [2:0] op, int pos, logic [31:0] val);
        req_item_t it;
        it.operation = op;
        it.position  = 7'(pos);
        it.value     = val;
        send_item(it);
    endtask

    function automatic req_item_t random_item(mix_t mix);
        req_item_t it;
        int        n;
        int        pick;
        int        ta, ti, tw, td, tr;
        n    = board.count;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin ta = 35; ti = 70; tw = 80; td = 85; tr = 95; end
            MIX_SHRINK: begin ta = 5;  ti = 15; tw = 25; td = 80; tr = 95; end
            default:    begin ta = 18; ti = 36; tw = 54; td = 72; tr = 95; end
        endcase
        if (pick < ta)
            it.operation = OP_APPEND;
        else if (pick < ti)
            it.operation = OP_INSERT;
        else if (pick < tw)
            it.operation = OP_OVERWRITE;
        else if (pick < td)
            it.operation = OP_DELETE;
        else if (pick < tr)
            it.operation = OP_READ;
        else
            it.operation = OP_SPARE_A + 3'($urandom_range(0, 2));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.position = 7'($urandom_range(0, 127));
        else if (pick == 1)
            it.position = 7'(n + $urandom_range(0, 2));
        else if (it.operation == OP_INSERT)
            it.position = 7'($urandom_range(0, n));
        else
            it.position = (n > 0) ? 7'($urandom_range(0, n - 1)) : 7'd0;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.value = 32'h0;
        else if (pick == 1)
            it.value = 32'hFFFF_FFFF;
        else
            it.value = $urandom;
        return it;
    endfunction

    initial
    begin
        int k;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: everything positional is out of range; then small-list edits, range and spare-code cases
        push(OP_READ,      0, 32'h0);
        push(OP_DELETE,    0, 32'h0);
        push(OP_OVERWRITE, 0, 32'h1111_1111);
        push(OP_INSERT,    1, 32'h2222_2222);
        push(OP_APPEND,    0, 32'h0);
        push(OP_INSERT,    0, 32'hFFFF_FFFF);
        push(OP_INSERT,    2, 32'hA5A5_5A5A);
        push(OP_INSERT,    4, 32'h3333_3333);
        push(OP_READ,      0, 32'h0);
        push(OP_READ,      1, 32'h0);
        push(OP_READ,      2, 32'h0);
        push(OP_OVERWRITE, 1, 32'h1234_5678);
        push(OP_READ,      3, 32'h0);
        push(OP_READ,      127, 32'hFFFF_FFFF);
        push(OP_SPARE_A,   0, 32'hFFFF_FFFF);
        push(OP_SPARE_B,   1, 32'h0);
        push(OP_SPARE_C,   127, 32'h5555_AAAA);
        push(OP_DELETE,    0, 32'h0);
        push(OP_DELETE,    1, 32'h0);
        push(OP_READ,      0, 32'h0);
        push(OP_DELETE,    0, 32'h0);
        push(OP_APPEND,    127, 32'hFFFF_FFFF);
        push(OP_OVERWRITE, 0, 32'h0);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 40 == 0)
                send_pace = pace_t'($urandom_range(0, 2));
            send_item(random_item(mix_t'((k / PHASE_ITEMS) % 3)));
        end
        req_valid <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        int taken;
        rsp_stall = 1'b0;
        taken     = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                take_pace = pace_t'($urandom_range(0, 2));
            wait_cycles = pick_wait(take_pace);
            if (wait_cycles > 0 || hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                while (hold_rsp) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            board.check_result(rsp);
            taken++;
        end
    end

    // long result hold-off so the block backs up into its input
    initial
    begin
        wait (accepted >= HOLD_AFTER);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

/* files.f */
sv/ili_pkg.sv
sv/ili_cell.sv
sv/indexed_list_insert_delete_top.sv
tb/tb.sv
